// ===== sv/evg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// evg_pkg
// Shared types, constants and the sine table of the ellipse vertex generator.
// ============================================================================
package evg_pkg;

    localparam int SINE_ENTRIES = 256;
    localparam int SINE_AW      = 8;
    localparam int QUARTER      = SINE_ENTRIES / 4;
    localparam logic [4:0] SEG_MAX = 5'd31;
    localparam logic [5:0] SEG_MIN = 6'd3;

    localparam logic signed [31:0] FACTOR_ONE = 32'sd32768;
    localparam logic [15:0]        TEX_HALF   = 16'd16384;

    // Vertex kinds handed from the sequencer to the arithmetic pipeline
    localparam logic [1:0] KIND_EMPTY  = 2'd0;
    localparam logic [1:0] KIND_CENTER = 2'd1;
    localparam logic [1:0] KIND_OUTER  = 2'd2;
    localparam logic [1:0] KIND_INNER  = 2'd3;

    typedef logic signed [16:0] t_trig;
    typedef t_trig [SINE_ENTRIES-1:0] t_sin_tab;

    typedef struct packed {
        logic              cmd;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic [22:0]       radius_x;
        logic [22:0]       radius_y;
        logic [5:0]        segment_count;
        logic [22:0]       ring_width;
    } t_in_word;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]       tex_u;
        logic [15:0]       tex_v;
        logic [5:0]        vertex_number;
        logic              empty_res;
        logic              last;
    } t_out_word;

    // One classified ellipse, ready for the vertex sequencer
    typedef struct packed {
        logic              empty;
        logic              cmd;
        logic [4:0]        segs;
        logic [7:0]        step_q;
        logic [4:0]        step_r;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [22:0]       rx;
        logic [22:0]       ry;
        logic signed [23:0] irx;
        logic signed [23:0] iry;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
    } t_job;

    // Quarter-wave folded Taylor sine in Q30, rounded to Q1.15
    function automatic t_trig sine_q15(input longint unsigned phase);
        longint unsigned quad;
        longint unsigned r;
        longint unsigned q;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned v;
        longint unsigned one;
        one  = 64'd1073741824;
        quad = (phase >> 30) & 64'd3;
        r    = phase & 64'h3FFFFFFF;
        q    = quad[0] ? one - r : r;
        x    = (q * 64'd6746518852) >> 32;
        x2   = (x * x) >> 30;
        t    = one;
        t    = one - ((x2 * t) >> 30) / 110;
        t    = one - ((x2 * t) >> 30) / 72;
        t    = one - ((x2 * t) >> 30) / 42;
        t    = one - ((x2 * t) >> 30) / 20;
        t    = one - ((x2 * t) >> 30) / 6;
        v    = (((x * t) >> 30) + 64'd16384) >> 15;
        if (v > 64'd32768) begin
            v = 64'd32768;
        end
        if (quad >= 64'd2) begin
            return -t_trig'(v);
        end
        return t_trig'(v);
    endfunction

    function automatic t_sin_tab build_sin_tab();
        t_sin_tab tab;
        longint unsigned phase;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            phase  = (longint'(k) << 32) / SINE_ENTRIES;
            tab[k] = sine_q15(phase);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

endpackage
`default_nettype wire

// ===== sv/evg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// evg_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module evg_div #(
    parameter int NW = 9,
    parameter int DW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo,
    output logic [DW-1:0]      o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          fits;

    always_comb begin
        shifted = {r_rem, r_quo[NW-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = shifted >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], fits};
            r_rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign o_done = !r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== sv/evg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// evg_queue
// Two-entry job queue between the classifier and the vertex sequencer.
// ============================================================================
module evg_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire evg_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output evg_pkg::t_job      o_job
);
    import evg_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_job   = r_mem[r_rptr];

endmodule
`default_nettype wire

// ===== sv/evg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// evg_front
// Accepts ellipse words, rejects degenerate ones, works out the angle step
// and the inner texture factors, then hands a job to the queue.
// ============================================================================
module evg_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire evg_pkg::t_in_word i_in_word,
    output logic                   o_push,
    output evg_pkg::t_job          o_job,
    input  wire logic              i_full
);
    import evg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    t_job        r_job;
    t_job        n_job;
    logic        accept;
    logic        rejected;
    logic [4:0]  segs_sat;
    logic signed [23:0] dx;
    logic signed [23:0] dy;
    logic [22:0] mag_x;
    logic [22:0] mag_y;
    logic        div_start;
    logic        seg_done;
    logic        fx_done;
    logic        fy_done;
    logic [8:0]  seg_quo;
    logic [5:0]  seg_rem;
    logic [37:0] fx_quo;
    logic [37:0] fy_quo;
    logic [22:0] fx_rem;
    logic [22:0] fy_rem;

    // Clamp a factor magnitude to 31 bits: anything larger already
    // saturates the texture coordinate for every nonzero sine.
    function automatic logic signed [31:0] make_factor(input logic [22:0] r,
                                                       input logic neg,
                                                       input logic [37:0] m);
        logic [30:0] mc;
        mc = (m > 38'h7FFFFFFF) ? 31'h7FFFFFFF : m[30:0];
        if (r == '0) begin
            return '0;
        end
        return neg ? -$signed({1'b0, mc}) : $signed({1'b0, mc});
    endfunction

    always_comb begin
        accept   = i_in_valid && o_in_ready;
        rejected = (i_in_word.segment_count < SEG_MIN)
                   || (i_in_word.cmd && i_in_word.ring_width == '0);
        segs_sat = (i_in_word.segment_count > {1'b0, SEG_MAX}) ? SEG_MAX
                                                               : i_in_word.segment_count[4:0];
        dx       = $signed({1'b0, i_in_word.radius_x}) - $signed({1'b0, i_in_word.ring_width});
        dy       = $signed({1'b0, i_in_word.radius_y}) - $signed({1'b0, i_in_word.ring_width});
        mag_x    = dx[23] ? 23'(-dx) : dx[22:0];
        mag_y    = dy[23] ? 23'(-dy) : dy[22:0];
        div_start = accept && !rejected;
    end

    evg_div #(.NW(9), .DW(6)) u_seg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (9'(SINE_ENTRIES)),
        .i_den   ({1'b0, segs_sat}),
        .o_done  (seg_done),
        .o_quo   (seg_quo),
        .o_rem   (seg_rem)
    );

    evg_div #(.NW(38), .DW(23)) u_fx_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({mag_x, 15'd0}),
        .i_den   (i_in_word.radius_x),
        .o_done  (fx_done),
        .o_quo   (fx_quo),
        .o_rem   (fx_rem)
    );

    evg_div #(.NW(38), .DW(23)) u_fy_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({mag_y, 15'd0}),
        .i_den   (i_in_word.radius_y),
        .o_done  (fy_done),
        .o_quo   (fy_quo),
        .o_rem   (fy_rem)
    );

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_job.empty = rejected;
                    n_job.cmd   = i_in_word.cmd;
                    n_job.segs  = segs_sat;
                    n_job.cx    = i_in_word.center_x;
                    n_job.cy    = i_in_word.center_y;
                    n_job.rx    = i_in_word.radius_x;
                    n_job.ry    = i_in_word.radius_y;
                    n_job.irx   = dx;
                    n_job.iry   = dy;
                    n_state     = rejected ? ST_PUSH : ST_DIV;
                end
            end
            ST_DIV: begin
                if (seg_done && fx_done && fy_done) begin
                    n_job.step_q = seg_quo[7:0];
                    n_job.step_r = seg_rem[4:0];
                    n_job.fx     = make_factor(r_job.rx, r_job.irx[23], fx_quo);
                    n_job.fy     = make_factor(r_job.ry, r_job.iry[23], fy_quo);
                    n_state      = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign o_in_ready = r_state == ST_IDLE;
    assign o_push     = (r_state == ST_PUSH) && !i_full;
    assign o_job      = r_job;

endmodule
`default_nettype wire

// ===== sv/evg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// evg_back
// Vertex sequencer and three-stage arithmetic pipeline: table lookup,
// multiply, then round, offset and saturate into the output register.
// ============================================================================
module evg_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire evg_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output evg_pkg::t_out_word o_out_word
);
    import evg_pkg::*;

    // Sequencer
    logic        r_busy;
    t_job        r_job;
    logic        r_ctr;
    logic        r_inner;
    logic [4:0]  r_i;
    logic [SINE_AW-1:0] r_k;
    logic [5:0]  r_acc;
    logic [5:0]  r_vn;
    logic        en;
    logic        issue;
    logic [1:0]  kind;
    logic        is_last;
    logic        step;
    logic [5:0]  acc_sum;
    logic [SINE_AW-1:0] k_cos;

    // Stage 1
    logic        r1_valid;
    logic [1:0]  r1_kind;
    logic [5:0]  r1_vn;
    logic        r1_last;
    t_trig       r1_c;
    t_trig       r1_s;
    logic signed [23:0] r1_cx;
    logic signed [23:0] r1_cy;
    logic signed [23:0] r1_rsx;
    logic signed [23:0] r1_rsy;
    logic signed [31:0] r1_fsx;
    logic signed [31:0] r1_fsy;

    // Stage 2
    logic        r2_valid;
    logic [1:0]  r2_kind;
    logic [5:0]  r2_vn;
    logic        r2_last;
    logic signed [23:0] r2_cx;
    logic signed [23:0] r2_cy;
    logic signed [40:0] r2_px;
    logic signed [40:0] r2_py;
    logic signed [48:0] r2_tu;
    logic signed [48:0] r2_tv;

    // Output register
    logic        r_o_valid;
    t_out_word   r_o_word;
    t_out_word   n_o_word;

    function automatic logic signed [23:0] pos_of(input logic signed [23:0] ctr,
                                                  input logic signed [40:0] p);
        logic signed [40:0] pr;
        logic signed [25:0] sum;
        pr  = p + 41'sd16384;
        sum = {{2{ctr[23]}}, ctr} + $signed(pr[40:15]);
        if (sum > 26'sd8388607) begin
            return 24'sh7FFFFF;
        end
        if (sum < -26'sd8388608) begin
            return 24'sh800000;
        end
        return sum[23:0];
    endfunction

    function automatic logic [15:0] tex_of(input logic signed [48:0] p);
        logic signed [48:0] pr;
        logic signed [33:0] u;
        pr = p + 49'sd32768;
        u  = 34'sd16384 + {pr[48], pr[48:16]};
        if (u < 34'sd0) begin
            return '0;
        end
        if (u > 34'sd32768) begin
            return 16'd32768;
        end
        return u[15:0];
    endfunction

    assign en = !r_o_valid || i_out_ready;

    always_comb begin
        issue   = r_busy && en;
        is_last = 1'b0;
        step    = 1'b0;
        if (r_job.empty) begin
            kind    = KIND_EMPTY;
            is_last = 1'b1;
        end else if (r_ctr) begin
            kind = KIND_CENTER;
        end else if (r_inner) begin
            kind    = KIND_INNER;
            is_last = r_i == r_job.segs;
            step    = 1'b1;
        end else begin
            kind    = KIND_OUTER;
            is_last = !r_job.cmd && (r_i == r_job.segs);
            step    = !r_job.cmd;
        end
        acc_sum = r_acc + {1'b0, r_job.step_r};
        k_cos   = r_k + SINE_AW'(QUARTER);
        o_pop   = !r_busy && !i_q_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (issue && is_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job   <= i_job;
            r_ctr   <= !i_job.cmd;
            r_inner <= 1'b0;
            r_i     <= '0;
            r_k     <= '0;
            r_acc   <= {2'b0, i_job.segs[4:1]};
            r_vn    <= '0;
        end else if (issue) begin
            r_vn <= r_vn + 1'b1;
            if (kind == KIND_CENTER) begin
                r_ctr <= 1'b0;
            end else if (kind == KIND_OUTER && r_job.cmd) begin
                r_inner <= 1'b1;
            end
            if (step) begin
                r_inner <= 1'b0;
                r_i     <= r_i + 1'b1;
                if (acc_sum >= {1'b0, r_job.segs}) begin
                    r_acc <= acc_sum - {1'b0, r_job.segs};
                    r_k   <= r_k + r_job.step_q + 1'b1;
                end else begin
                    r_acc <= acc_sum;
                    r_k   <= r_k + r_job.step_q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r1_valid  <= issue;
            r2_valid  <= r1_valid;
            r_o_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= kind;
            r1_vn   <= r_vn;
            r1_last <= is_last;
            r1_c    <= $signed(SIN_TAB[k_cos]);
            r1_s    <= $signed(SIN_TAB[r_k]);
            r1_cx   <= r_job.cx;
            r1_cy   <= r_job.cy;
            if (kind == KIND_INNER) begin
                r1_rsx <= r_job.irx;
                r1_rsy <= r_job.iry;
                r1_fsx <= r_job.fx;
                r1_fsy <= r_job.fy;
            end else begin
                r1_rsx <= $signed({1'b0, r_job.rx});
                r1_rsy <= $signed({1'b0, r_job.ry});
                r1_fsx <= FACTOR_ONE;
                r1_fsy <= FACTOR_ONE;
            end

            r2_kind <= r1_kind;
            r2_vn   <= r1_vn;
            r2_last <= r1_last;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
            r2_px   <= r1_c * r1_rsx;
            r2_py   <= r1_s * r1_rsy;
            r2_tu   <= r1_c * r1_fsx;
            r2_tv   <= r1_s * r1_fsy;

            r_o_word <= n_o_word;
        end
    end

    always_comb begin
        n_o_word.vertex_number = r2_vn;
        n_o_word.last          = r2_last;
        n_o_word.empty_res     = 1'b0;
        unique case (r2_kind)
            KIND_EMPTY: begin
                n_o_word.pos_x         = '0;
                n_o_word.pos_y         = '0;
                n_o_word.tex_u         = '0;
                n_o_word.tex_v         = '0;
                n_o_word.vertex_number = '0;
                n_o_word.empty_res     = 1'b1;
            end
            KIND_CENTER: begin
                n_o_word.pos_x = r2_cx;
                n_o_word.pos_y = r2_cy;
                n_o_word.tex_u = TEX_HALF;
                n_o_word.tex_v = TEX_HALF;
            end
            default: begin
                n_o_word.pos_x = pos_of(r2_cx, r2_px);
                n_o_word.pos_y = pos_of(r2_cy, r2_py);
                n_o_word.tex_u = tex_of(r2_tu);
                n_o_word.tex_v = tex_of(r2_tv);
            end
        endcase
    end

    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

endmodule
`default_nettype wire

// ===== sv/ellipse_vertex_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A rejected ellipse passes straight through the queue and the vertex
// pipeline; a valid one first waits for the serial dividers, of which the
// 38-step ones that form the inner texture factors take longest.
// The vertex pipeline emits one word per cycle while the output is not
// stalled, up to 64 per ellipse, while the classifier prepares the next
// ellipse in parallel. Reset is synchronous and clears all control state;
// no clearing pass is needed.
// ============================================================================
// ellipse_vertex_generator
// Tessellates an axis-aligned ellipse into a triangle fan or an outline ring.
// ============================================================================
module ellipse_vertex_generator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire evg_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output evg_pkg::t_out_word      o_out_word
);
    import evg_pkg::*;

    // The front end takes one word at a time: it rejects degenerate
    // ellipses, saturates the segment count, and runs three serial dividers
    // in parallel: one for the angle step (table entries per segment, as a
    // quotient and a remainder) and two for the inner texture factors.
    logic push;
    logic full;
    logic pop;
    logic q_empty;
    t_job front_job;
    t_job queue_job;

    evg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_push     (push),
        .o_job      (front_job),
        .i_full     (full)
    );

    // The queue lets the classifier work on the next ellipse while the
    // sequencer is still emitting the vertices of the current one.
    evg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (queue_job)
    );

    // The back end walks the rim angles with a quotient-and-remainder
    // accumulator, so the table index of each angle is found without a
    // divider, and pushes one vertex a cycle through its pipeline. The whole
    // pipeline stalls together when the output word is held by the sink.
    evg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("job popped from an empty queue");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.empty_res |-> o_out_word.last
            && o_out_word.vertex_number == 6'd0)
        else $error("empty result is not a lone final word");
`endif

endmodule
`default_nettype wire

// ===== verif/ellipse_vertex_generator_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Ellipse vertex generator testbench
// Feeds filled and outlined ellipse requests through the valid/ready input,
// predicts every vertex word with an independent fixed-point model and checks
// the output words in order, with random bursts, gaps and output stalls.
// ============================================================================

import evg_pkg::*;

// Holds the vertex words still owed by the block and compares arrivals.
class vertex_scoreboard;
    t_out_word owed[$];
    int        mismatches;
    int        owed_run;

    // Quarter-wave Taylor sine, Q30 working precision, rounded to Q1.15.
    static function int trig_q15(longint unsigned phase);
        longint unsigned quad, r, q, x, x2, t, v, one;
        one  = 64'd1073741824;
        quad = (phase >> 30) & 64'd3;
        r    = phase & 64'h3FFFFFFF;
        q    = quad[0] ? one - r : r;
        x    = (q * 64'd6746518852) >> 32;
        x2   = (x * x) >> 30;
        t    = one;
        t    = one - ((x2 * t) >> 30) / 110;
        t    = one - ((x2 * t) >> 30) / 72;
        t    = one - ((x2 * t) >> 30) / 42;
        t    = one - ((x2 * t) >> 30) / 20;
        t    = one - ((x2 * t) >> 30) / 6;
        v    = (((x * t) >> 30) + 64'd16384) >> 15;
        if (v > 64'd32768) v = 64'd32768;
        return (quad >= 2) ? -int'(v) : int'(v);
    endfunction

    static function logic signed [23:0] clamp24(longint v);
        if (v > 8388607) return 24'sd8388607;
        if (v < -8388608) return -24'sd8388608;
        return v[23:0];
    endfunction

    // Arithmetic shift gives floor, so adding half first rounds half up.
    static function logic signed [23:0] place(longint c, int trig, longint r);
        longint p;
        p = longint'(trig) * r;
        return clamp24(c + ((p + 16384) >>> 15));
    endfunction

    static function logic [15:0] tex(int trig, longint f);
        longint u;
        u = 16384 + ((longint'(trig) * f + 32768) >>> 16);
        if (u < 0) u = 0;
        if (u > 32768) u = 32768;
        return u[15:0];
    endfunction

    static function longint shrink(longint r, longint w);
        longint d, m;
        if (r == 0) return 0;
        d = r - w;
        m = ((d < 0 ? -d : d) << 15) / r;
        return d < 0 ? -m : m;
    endfunction

    function void push(logic signed [23:0] px, logic signed [23:0] py,
                       logic [15:0] u, logic [15:0] v, logic e);
        t_out_word o;
        o.pos_x = px; o.pos_y = py; o.tex_u = u; o.tex_v = v;
        o.vertex_number = 6'(owed_run);
        o.empty_res = e; o.last = 1'b0;
        owed.push_back(o);
        owed_run++;
    endfunction

    // Expand one accepted request into its expected vertex words.
    function void note_ellipse(t_in_word w);
        longint cx, cy, rx, ry, rw, fx, fy, k, segs;
        longint unsigned ph;
        int s, c;
        owed_run = 0;
        cx = w.center_x; cy = w.center_y;
        rx = w.radius_x; ry = w.radius_y; rw = w.ring_width;
        segs = w.segment_count;
        if (segs < 3 || (w.cmd && rw == 0)) begin
            push('0, '0, '0, '0, 1'b1);
        end else begin
            if (segs > 31) segs = 31;
            fx = 32768; fy = 32768;
            if (!w.cmd) begin
                push(clamp24(cx), clamp24(cy), 16'd16384, 16'd16384, 1'b0);
            end else begin
                fx = shrink(rx, rw);
                fy = shrink(ry, rw);
            end
            for (longint i = 0; i <= segs; i++) begin
                k  = ((i * 256 + segs / 2) / segs) % 256;
                ph = (longint'(k) << 32) / 256;
                s  = trig_q15(ph);
                c  = trig_q15((ph + 64'h40000000) & 64'hFFFFFFFF);
                push(place(cx, c, rx), place(cy, s, ry), tex(c, 32768), tex(s, 32768), 1'b0);
                if (w.cmd) begin
                    push(place(cx, c, rx - rw), place(cy, s, ry - rw),
                         tex(c, fx), tex(s, fy), 1'b0);
                end
            end
        end
        owed[$].last = 1'b1;
    endfunction

    function void check_vertex(t_out_word got);
        t_out_word exp_w;
        if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected vertex word %h", got);
            return;
        end
        exp_w = owed.pop_front();
        if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Vertex mismatch: expected x=%0d y=%0d u=%0d v=%0d n=%0d e=%0b l=%0b",
                         exp_w.pos_x, exp_w.pos_y, exp_w.tex_u, exp_w.tex_v,
                         exp_w.vertex_number, exp_w.empty_res, exp_w.last);
                $display("                 actual   x=%0d y=%0d u=%0d v=%0d n=%0d e=%0b l=%0b",
                         got.pos_x, got.pos_y, got.tex_u, got.tex_v,
                         got.vertex_number, got.empty_res, got.last);
            end
        end
    endfunction
endclass

module ellipse_vertex_generator_test;

    localparam int IDLE_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    vertex_scoreboard board = new();

    // Set by the stimulus to run the receiver hold-off, cleared once it is done.
    logic hold_request = 1'b0;
    logic hold_active  = 1'b0;
    int   idle_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ellipse_vertex_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // Output side: checks every accepted word and stalls on its own pattern,
    // alternating stretches of free flow with stretches of random stalls.
    // When a hold-off is requested it stays low for a long counted stretch.
    always @(posedge i_clk) begin
        static int phase_left = 0;
        static bit choppy = 0;
        static int hold_left = 0;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_vertex(o_out_word);
        end
        if (hold_request && !hold_active) begin
            hold_active <= 1'b1;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
            if (hold_left == 0) hold_request <= 1'b0;
        end else begin
            hold_active <= 1'b0;
            if (phase_left == 0) begin
                phase_left = $urandom_range(5, 80);
                choppy = $urandom_range(0, 1);
            end
            phase_left--;
            i_out_ready <= choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Watchdog: counts cycles in which neither side moves a word.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding", board.owed.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offers one request and waits until the block takes it. Valid stays high
    // with the word unchanged until the handshake; the caller drops it before
    // any pause.
    task automatic send_ellipse(t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_ellipse(w);
    endtask

    // Always lets at least one edge pass, so valid never gets two updates
    // in the same step.
    task automatic wait_drained();
        do @(posedge i_clk); while (board.owed.size() != 0);
    endtask

    function automatic t_in_word make_request(logic cmd, int segs);
        t_in_word w;
        w.cmd           = cmd;
        w.center_x      = 24'($urandom);
        w.center_y      = 24'($urandom);
        w.segment_count = 6'(segs);
        // Mostly moderate radii, sometimes anything up to full scale.
        case ($urandom_range(0, 3))
            0: begin
                w.radius_x = 23'($urandom);
                w.radius_y = 23'($urandom);
            end
            1: begin
                w.radius_x = 23'($urandom_range(0, 255));
                w.radius_y = 23'($urandom_range(0, 255));
            end
            default: begin
                w.radius_x = 23'($urandom_range(0, 200000));
                w.radius_y = 23'($urandom_range(0, 200000));
            end
        endcase
        // Thickness below the radius most of the time, beyond it sometimes.
        case ($urandom_range(0, 3))
            0: w.ring_width = 23'($urandom);
            1: w.ring_width = 23'($urandom_range(0, 3));
            default: w.ring_width = 23'($urandom_range(1, int'(w.radius_x) + 1));
        endcase
        return w;
    endfunction

    task automatic run_directed();
        t_in_word w;
        // Full-scale fields in both modes; positions must saturate.
        w = '{1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 6'd63, 23'h7FFFFF};
        send_ellipse(w);
        w = '{1'b0, -24'sh800000, -24'sh800000, 23'h7FFFFF, 23'h7FFFFF, 6'd31, 23'd0};
        send_ellipse(w);
        w = '{1'b1, 24'sh7FFFFF, -24'sh800000, 23'h7FFFFF, 23'h7FFFFF, 6'd32, 23'h7FFFFF};
        send_ellipse(w);
        w = '{1'b0, 24'sd0, 24'sd0, 23'd0, 23'd0, 6'd3, 23'd0};
        send_ellipse(w);
        // Too few segments, in both modes.
        for (int s = 0; s < 3; s++) begin
            send_ellipse(make_request(s[0], s));
        end
        // Outlined with zero thickness gives the empty word.
        w = make_request(1'b1, 8);
        w.ring_width = 23'd0;
        send_ellipse(w);
        // Zero radius on one axis: inner texture factor collapses to zero.
        w = '{1'b1, 24'sd1000, -24'sd1000, 23'd0, 23'd5000, 6'd6, 23'd100};
        send_ellipse(w);
        // Thickness beyond the radius: the inner point crosses the centre.
        w = '{1'b1, 24'sd0, 24'sd0, 23'd300, 23'd700, 6'd12, 23'd2000};
        send_ellipse(w);
        // Thickness equal to the radius.
        w = '{1'b1, 24'sd256, 24'sd256, 23'd4096, 23'd4096, 6'd5, 23'd4096};
        send_ellipse(w);
        // Segment counts around the saturation point and the minimum.
        send_ellipse(make_request(1'b0, 30));
        send_ellipse(make_request(1'b1, 31));
        send_ellipse(make_request(1'b0, 33));
        send_ellipse(make_request(1'b1, 3));
        send_ellipse(make_request(1'b0, 4));
    endtask

    initial begin
        t_in_word w;
        int burst;
        int sent;
        int gap;
        bit drain;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Random part: bursts of requests with random gaps. Most requests are
        // well formed; roughly one in eight is degenerate.
        sent = 0;
        while (sent < 300) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                if ($urandom_range(0, 7) == 0) begin
                    w = make_request(1'($urandom_range(0, 1)), $urandom_range(0, 2));
                end else if ($urandom_range(0, 3) == 0) begin
                    w = make_request(1'($urandom_range(0, 1)), $urandom_range(32, 63));
                end else begin
                    w = make_request(1'($urandom_range(0, 1)), $urandom_range(3, 31));
                end
                send_ellipse(w);
                sent++;
            end
            // Once, stop the receiver for a long stretch while requests
            // keep coming, so that the block backs up into its input.
            if (sent >= 100 && sent < 100 + burst) begin
                hold_request <= 1'b1;
            end
            // Once, let the block empty completely before going on.
            drain = (sent >= 200 && sent < 200 + burst);
            gap   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 120) : 0;
            if (drain || gap > 0) begin
                i_in_valid <= 1'b0;
            end
            if (drain) begin
                wait_drained();
            end
            repeat (gap) @(posedge i_clk);
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (board.mismatches == 0 && board.owed.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
